>>> hdl/causal_attention_head_assert.svh
// Assertion shorthands for the attention head, clocked on i_clk, held off in reset
`ifndef CAUSAL_ATTENTION_HEAD_ASSERT_SVH
`define CAUSAL_ATTENTION_HEAD_ASSERT_SVH

// Check a consequence in the same cycle
`define CAH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle
`define CAH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cah_pkg.sv
`default_nettype none
package cah_pkg;

    // Input beat kinds
    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;
    localparam logic [1:0] KIND_START = 2'd3;

    // Register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_POS  = 2'd1;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int VAL_W       = 16;
    localparam int DOT_W       = 38;
    localparam int INV_W       = 16;
    localparam int SPROD_W     = DOT_W + INV_W + 1;
    localparam int SCORE_SHIFT = 27;
    localparam int SC_W        = SPROD_W - SCORE_SHIFT;
    localparam int T_W         = SC_W + 1;
    localparam int LOG2E_W     = 12;
    localparam int U_W         = T_W + LOG2E_W - 11;
    localparam int W_W         = 17;
    localparam int SUM_W       = 25;
    localparam int PROD_W      = 34;
    localparam int ACC_W       = 41;
    localparam int DIV_W       = 41;
    localparam int CNT_W       = 6;
    localparam logic [LOG2E_W-1:0] LOG2E_Q11 = 12'd2955;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DOT  = 6'b000010,
        S_SUM  = 6'b000100,
        S_MAC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    // 2^(-k/16) in Q.16
    function automatic logic [W_W-1:0] pow2_frac(input logic [4:0] k);
        logic [W_W-1:0] r;
        unique case (k)
            5'd0:  r = 17'd65536;
            5'd1:  r = 17'd62757;
            5'd2:  r = 17'd60097;
            5'd3:  r = 17'd57549;
            5'd4:  r = 17'd55110;
            5'd5:  r = 17'd52773;
            5'd6:  r = 17'd50535;
            5'd7:  r = 17'd48393;
            5'd8:  r = 17'd46341;
            5'd9:  r = 17'd44376;
            5'd10: r = 17'd42495;
            5'd11: r = 17'd40693;
            5'd12: r = 17'd38968;
            5'd13: r = 17'd37316;
            5'd14: r = 17'd35734;
            5'd15: r = 17'd34219;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/causal_attention_head.sv
`default_nettype none
`include "causal_attention_head_assert.svh"
// Causal single-head attention for one query vector. Load beats (query, key,
// value elements) are taken one per cycle while idle and write straight into on-chip
// memories; keys and values beyond the stored columns or rows are dropped. A
// start beat runs the whole head and the block takes no further beat until the
// last result has been handed to the output register. A run covers positions 0 up to
// last_position, clamped to the stored rows, and D = min(HEAD_DIM, 64) elements:
// the key and value memories have one read port, so each score reads its row one
// element a cycle, each output element walks all weights once, and each output
// is divided by a bit-serial divider of 41 steps. Memories need no clearing
// after reset.
module causal_attention_head #(
    parameter int SEQ_DEPTH = 256,
    parameter int HEAD_DIM  = 64
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  [1:0]                      i_kind,
    input  wire  [7:0]                      i_position,
    input  wire  [5:0]                      i_element,
    input  wire  signed [15:0]              i_value,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [5:0]                      o_out_index,
    output logic signed [15:0]              o_out_value,
    output logic                            o_last,
    input  wire                             i_cfg_we,
    input  wire  [cah_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [cah_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cah_pkg::*;

    localparam int RUN_DIM = (HEAD_DIM < 64) ? HEAD_DIM : 64;
    localparam int MIN_SEQ = (SEQ_DEPTH < 256) ? SEQ_DEPTH : 256;
    localparam int CW = $clog2(RUN_DIM);
    localparam int RW = $clog2(MIN_SEQ);
    localparam int AW = RW + CW;
    localparam int KV_DEPTH = MIN_SEQ * (2 ** CW);
    localparam logic [CW-1:0] LAST_COL = CW'(RUN_DIM - 1);
    localparam logic [RW-1:0] MAX_ROW  = RW'(MIN_SEQ - 1);

    // Memories
    logic signed [VAL_W-1:0] r_qmem [RUN_DIM];
    logic signed [VAL_W-1:0] r_kmem [KV_DEPTH];
    logic signed [VAL_W-1:0] r_vmem [KV_DEPTH];
    logic signed [SC_W-1:0]  r_smem [MIN_SEQ];
    logic signed [VAL_W-1:0] r_q_rd, r_k_rd, r_v_rd;
    logic signed [SC_W-1:0]  r_s_rd;

    // Control
    t_state          r_state;
    logic            r_iss;
    logic [RW-1:0]   r_row, r_lastp;
    logic [CW-1:0]   r_col;
    logic            r_v1, r_v2, r_v3, r_v4;
    logic [CNT_W-1:0] r_cnt;
    logic [INV_W-1:0] r_inv;
    logic [7:0]      r_lastpos;
    logic            r_out_valid, r_out_last;
    logic [5:0]      r_out_index;
    logic signed [VAL_W-1:0] r_out_value;

    // Stage payload
    logic            r_first1, r_end1, r_first2, r_end2;
    logic [RW-1:0]   r_row1, r_row2, r_row3, r_row4;
    logic signed [PROD_W-1:0]  r_prod2;
    logic [U_W-1:0]            r_u;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DOT_W-1:0]   r_dot;
    logic [W_W-1:0]            r_m;
    logic [4:0]                r_n;
    logic                      r_zero;
    logic signed [SPROD_W-1:0] r_sprod;
    logic signed [SC_W-1:0]    r_max;
    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          r_rem;
    logic [DIV_W-1:0]          r_quo;
    logic                      r_neg;

    logic w_in_acc, w_load_ok, w_row_ok;
    logic [AW-1:0] w_wr_addr, w_rd_addr;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [T_W-1:0]     w_t;
    logic [T_W+LOG2E_W-1:0]    w_umul;
    logic [W_W-1:0]            w_tab0, w_tab1, w_m;
    logic [18:0]               w_interp;
    logic [W_W:0]              w_round;
    logic [W_W-1:0]            w_weight;
    logic signed [ACC_W-1:0]   w_acc_nxt;
    logic [DIV_W-1:0]          w_mag;
    logic signed [SPROD_W-1:0] w_sround;
    logic signed [SC_W-1:0]    w_score;
    logic [SUM_W:0]            w_trial;
    logic [W_W-1:0]            w_sat;
    logic signed [VAL_W-1:0]   w_res;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_load_ok = w_in_acc && (i_kind != KIND_START) && (int'(i_element) < RUN_DIM);
    assign w_row_ok  = int'(i_position) < MIN_SEQ;
    assign w_wr_addr = {i_position[RW-1:0], i_element[CW-1:0]};
    assign w_rd_addr = {r_row, r_col};

    // Load writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_load_ok && i_kind == KIND_QUERY) r_qmem[i_element[CW-1:0]] <= i_value;
        if (w_load_ok && i_kind == KIND_KEY && w_row_ok) r_kmem[w_wr_addr] <= i_value;
        if (w_load_ok && i_kind == KIND_VALUE && w_row_ok) r_vmem[w_wr_addr] <= i_value;
        r_q_rd <= r_qmem[r_col];
        r_k_rd <= r_kmem[w_rd_addr];
        r_v_rd <= r_vmem[w_rd_addr];
    end

    // Score / weight memory: scores written in the dot phase, replaced by weights
    always_ff @(posedge i_clk) begin
        if (r_v4) r_smem[r_row4] <= w_score;
        else if (r_v3 && r_state == S_SUM) r_smem[r_row3] <= SC_W'(w_weight);
        r_s_rd <= r_smem[r_row];
    end

    // Products for the dot phase and the value phase
    always_comb begin
        if (r_state == S_DOT) w_prod = PROD_W'(r_q_rd * r_k_rd);
        else w_prod = PROD_W'($signed({1'b0, r_s_rd[W_W-1:0]}) * r_v_rd);
    end

    assign w_acc_nxt = (r_first2 ? '0 : r_acc) + ACC_W'(r_prod2);

    // Exp stage one: t*log2(e) in Q.11
    assign w_t    = T_W'(r_max) - T_W'(r_s_rd);
    assign w_umul = (T_W + LOG2E_W)'(w_t) * (T_W + LOG2E_W)'(LOG2E_Q11)
                    + (T_W + LOG2E_W)'(1024);

    // Exp stage two: table with linear interpolation
    assign w_tab0   = pow2_frac({1'b0, r_u[10:7]});
    assign w_tab1   = pow2_frac(5'({1'b0, r_u[10:7]} + 5'd1));
    assign w_interp = 19'(12'(w_tab0 - w_tab1) * 19'(r_u[6:0])) + 19'd64;
    assign w_m      = w_tab0 - W_W'(w_interp[18:7]);

    // Exp stage three: rounded shift by the integer part
    assign w_round  = ({1'b0, r_m} + ((W_W + 1)'(1) << (r_n - 5'd1))) >> r_n;
    assign w_weight = r_zero ? '0 : ((r_n == 5'd0) ? r_m : w_round[W_W-1:0]);

    // Score rounding, half up
    assign w_sround = r_sprod + (SPROD_W'(1) <<< (SCORE_SHIFT - 1));
    assign w_score  = w_sround[SPROD_W-1:SCORE_SHIFT];

    // Divider trial subtract, and saturation of the quotient
    assign w_mag   = (w_acc_nxt < 0) ? DIV_W'(-w_acc_nxt) : DIV_W'(w_acc_nxt);
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_sat   = (r_quo > DIV_W'(32768)) ? W_W'(32768) : r_quo[W_W-1:0];
    always_comb begin
        if (r_sum == '0) w_res = '0;
        else if (r_neg) w_res = VAL_W'(-$signed({1'b0, w_sat}));
        else if (w_sat > W_W'(32767)) w_res = 16'sh7fff;
        else w_res = $signed(w_sat[VAL_W-1:0]);
    end

    // Control: state, issue counters, stage valids, registers, output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iss       <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_lastp     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_cnt       <= '0;
            r_inv       <= 16'd8192;
            r_lastpos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_INV_SCALE) r_inv <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_LAST_POS) r_lastpos <= i_cfg_data[7:0];
            r_v1 <= r_iss;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && ((r_state == S_DOT && r_end2) || r_state == S_SUM);
            r_v4 <= r_v3 && (r_state == S_DOT);
            // load a new output beat, or drop the one taken
            if (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            // advance the read address
            if (r_iss) begin
                if (r_state == S_DOT && r_col != LAST_COL) begin
                    r_col <= r_col + 1'b1;
                end else begin
                    if (r_state == S_DOT) r_col <= '0;
                    if (r_row == r_lastp) r_iss <= 1'b0;
                    else r_row <= r_row + 1'b1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_kind == KIND_START) begin
                        r_state <= S_DOT;
                        r_iss   <= 1'b1;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_lastp <= (int'(r_lastpos) > MIN_SEQ - 1) ? MAX_ROW
                                                                   : r_lastpos[RW-1:0];
                    end
                end
                S_DOT: begin
                    if (r_v4 && r_row4 == r_lastp) begin
                        r_state <= S_SUM;
                        r_iss   <= 1'b1;
                        r_row   <= '0;
                    end
                end
                S_SUM: begin
                    if (r_v3 && r_row3 == r_lastp) begin
                        r_state <= S_MAC;
                        r_iss   <= 1'b1;
                        r_row   <= '0;
                        r_col   <= '0;
                    end
                end
                S_MAC: begin
                    if (r_v2 && r_end2) begin
                        r_state <= S_DIV;
                        r_cnt   <= CNT_W'(DIV_W);
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        if (r_col == LAST_COL) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_MAC;
                            r_col   <= r_col + 1'b1;
                            r_row   <= '0;
                            r_iss   <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        r_first1 <= (r_state == S_DOT) ? (r_col == '0) : (r_row == '0);
        r_end1   <= (r_state == S_DOT) ? (r_col == LAST_COL) : (r_row == r_lastp);
        r_row1   <= r_row;
        r_first2 <= r_first1;
        r_end2   <= r_end1;
        r_row2   <= r_row1;
        r_row3   <= r_row2;
        r_row4   <= r_row3;
        r_prod2  <= w_prod;
        r_u      <= w_umul[T_W+LOG2E_W-1:11];
        r_m      <= w_m;
        r_n      <= r_u[15:11];
        r_zero   <= (r_u[U_W-1:11] >= (U_W - 11)'(17));
        r_sprod  <= SPROD_W'(r_dot) * SPROD_W'($signed({1'b0, r_inv}));
        if (r_v2) r_acc <= w_acc_nxt;
        if (r_v2 && r_end2) r_dot <= w_acc_nxt[DOT_W-1:0];
        // running maximum over the scores in position order
        if (r_v4 && (r_row4 == '0 || w_score > r_max)) r_max <= w_score;
        // weight sum
        if (r_state == S_IDLE) r_sum <= '0;
        else if (r_v3 && r_state == S_SUM) r_sum <= r_sum + SUM_W'(w_weight);
        // divider: load magnitude plus half divisor, then one bit a cycle
        if (r_state == S_MAC && r_v2 && r_end2) begin
            r_neg <= (w_acc_nxt < 0);
            r_quo <= w_mag + DIV_W'(r_sum >> 1);
            r_rem <= '0;
        end else if (r_state == S_DIV) begin
            if (w_trial >= {1'b0, r_sum}) begin
                r_rem <= SUM_W'(w_trial - {1'b0, r_sum});
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[SUM_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
        // output register
        if (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) begin
            r_out_index <= 6'(r_col);
            r_out_value <= w_res;
            r_out_last  <= (r_col == LAST_COL);
        end
    end

    `CAH_ASSERT_NOW(a_pipe_empty_idle, r_state == S_IDLE, !(r_iss || r_v1 || r_v2 || r_v3 || r_v4), "pipeline busy while idle")
    `CAH_ASSERT_NOW(a_sum_floor, r_state == S_MAC || r_state == S_DIV || r_state == S_EMIT, r_sum >= SUM_W'(65536), "weight sum below one")
    `CAH_ASSERT_NOW(a_weight_max, r_v3 && r_state == S_SUM, w_weight <= W_W'(65536), "weight above one")
    `CAH_ASSERT_NEXT(a_start_runs, i_in_valid && !o_in_stall && i_kind == KIND_START, r_state == S_DOT && r_iss, "start beat did not launch a run")

endmodule
`default_nettype wire
